[rtl/core/tga_rle_pixel_decoder_macros.svh]
// Assertion helpers shared by the decoder RTL.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TGA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// Next-cycle implication, checked outside reset.
`define TGA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

[rtl/core/tga_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tga_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic [31:0] pixel_index;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        end_of_image;
    } out_beat_t;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_PACKET = 5'b00010,
        PH_PIXEL  = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_REJECT = 5'b10000
    } phase_t;

    localparam logic [1:0] KIND_PIXEL     = 2'd0;
    localparam logic [1:0] KIND_HEADER_OK = 2'd1;
    localparam logic [1:0] KIND_BAD_DEPTH = 2'd2;
    localparam logic [1:0] KIND_BAD_TYPE  = 2'd3;

    localparam logic [4:0] HDR_POS_TYPE     = 5'd2;
    localparam logic [4:0] HDR_POS_WIDTH_LO = 5'd12;
    localparam logic [4:0] HDR_POS_WIDTH_HI = 5'd13;
    localparam logic [4:0] HDR_POS_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_POS_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_POS_DEPTH    = 5'd16;
    localparam logic [4:0] HDR_POS_LAST     = 5'd17;

    localparam logic [7:0]  TYPE_RAW = 8'd2;
    localparam logic [7:0]  TYPE_RLE = 8'd10;
    localparam logic [23:0] DEPTH_24 = 24'd24;
    localparam logic [23:0] DEPTH_32 = 24'd32;
    localparam logic [7:0]  RUN_FLAG = 8'd128;
    localparam logic [7:0]  RUN_BIAS = 8'd127;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

endpackage

`default_nettype wire

[rtl/core/tga_rle_pixel_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

// Channel | Handshake           | Payload                      | Beat
// input   | in_valid/in_ready   | tga_pkg::in_beat_t in_data   | one file byte
// output  | out_valid/out_ready | tga_pkg::out_beat_t out_data | one header or pixel result
//
// One byte is taken per cycle while in_ready is high; each byte gives at most one result.
// A byte's result is loaded at the edge that accepts it, into the output or skid register.
// A skid register behind the output holds one more result while the output waits, so
// in_ready drops only when both are full and rises again after the edge that drains one.
// Reset (rst_n low, asynchronous) returns the parser to the header and empties the output.
// file_start on a byte restarts the parser at that byte.

module tga_rle_pixel_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tga_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tga_pkg::out_beat_t      out_data
);

    tga_pkg::phase_t    phase_reg, phase_next;
    logic [4:0]         hpos_reg, hpos_next;
    logic [7:0]         img_kind_reg, img_kind_next;
    logic [15:0]        width_reg, width_next;
    logic [15:0]        height_reg, height_next;
    logic               four_bpp_reg, four_bpp_next;
    logic [7:0]         remain_reg, remain_next;
    logic               is_run_reg, is_run_next;
    logic [1:0]         bpos_reg, bpos_next;
    logic [23:0]        held_reg, held_next;
    logic [31:0]        done_reg, done_next;
    logic [31:0]        total_reg, total_next;

    tga_pkg::phase_t    cur_phase;
    logic [4:0]         cur_hpos;
    logic [7:0]         cur_img_kind;
    logic [15:0]        cur_width;
    logic [15:0]        cur_height;
    logic               cur_four_bpp;
    logic [7:0]         cur_remain;
    logic               cur_is_run;
    logic [1:0]         cur_bpos;
    logic [23:0]        cur_held;
    logic [31:0]        cur_done;
    logic [31:0]        cur_total;

    logic [7:0]         b;
    logic [1:0]         last_pos;
    logic [31:0]        left;
    logic [31:0]        rep;
    logic [31:0]        product;
    logic               has_result;
    tga_pkg::out_beat_t result;

    logic               out_valid_reg;
    tga_pkg::out_beat_t out_reg;
    logic               skid_valid_reg;
    tga_pkg::out_beat_t skid_reg;
    logic               in_fire;
    logic               out_fire;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign b        = in_data.data_byte;
    assign last_pos = cur_four_bpp ? 2'd3 : 2'd2;
    assign left     = cur_total - cur_done;
    assign product  = 32'(cur_width) * 32'(cur_height);

    always_comb
    begin
        if (in_data.file_start)
        begin
            cur_phase    = tga_pkg::PH_HEADER;
            cur_hpos     = '0;
            cur_img_kind = '0;
            cur_width    = '0;
            cur_height   = '0;
            cur_four_bpp = 1'b0;
            cur_remain   = '0;
            cur_is_run   = 1'b0;
            cur_bpos     = '0;
            cur_held     = '0;
            cur_done     = '0;
            cur_total    = '0;
        end
        else
        begin
            cur_phase    = phase_reg;
            cur_hpos     = hpos_reg;
            cur_img_kind = img_kind_reg;
            cur_width    = width_reg;
            cur_height   = height_reg;
            cur_four_bpp = four_bpp_reg;
            cur_remain   = remain_reg;
            cur_is_run   = is_run_reg;
            cur_bpos     = bpos_reg;
            cur_held     = held_reg;
            cur_done     = done_reg;
            cur_total    = total_reg;
        end
    end

    always_comb
    begin
        phase_next    = cur_phase;
        hpos_next     = cur_hpos;
        img_kind_next = cur_img_kind;
        width_next    = cur_width;
        height_next   = cur_height;
        four_bpp_next = cur_four_bpp;
        remain_next   = cur_remain;
        is_run_next   = cur_is_run;
        bpos_next     = cur_bpos;
        held_next     = cur_held;
        done_next     = cur_done;
        total_next    = cur_total;
        has_result    = 1'b0;
        result        = '0;
        rep           = 32'd1;

        unique case (cur_phase)
            tga_pkg::PH_HEADER:
            begin
                unique case (cur_hpos)
                    tga_pkg::HDR_POS_TYPE:      img_kind_next = b;
                    tga_pkg::HDR_POS_WIDTH_LO:  width_next[7:0] = b;
                    tga_pkg::HDR_POS_WIDTH_HI:  width_next[15:8] = b;
                    tga_pkg::HDR_POS_HEIGHT_LO: height_next[7:0] = b;
                    tga_pkg::HDR_POS_HEIGHT_HI: height_next[15:8] = b;
                    tga_pkg::HDR_POS_DEPTH:     held_next = {16'd0, b};
                    default:                    ;
                endcase
                if (cur_hpos != tga_pkg::HDR_POS_LAST)
                begin
                    hpos_next = cur_hpos + 5'd1;
                end
                else
                begin
                    hpos_next           = '0;
                    has_result          = 1'b1;
                    result.image_width  = cur_width;
                    result.image_height = cur_height;
                    if (cur_held != tga_pkg::DEPTH_24 && cur_held != tga_pkg::DEPTH_32)
                    begin
                        result.kind = tga_pkg::KIND_BAD_DEPTH;
                        phase_next  = tga_pkg::PH_REJECT;
                    end
                    else if (cur_img_kind != tga_pkg::TYPE_RAW
                             && cur_img_kind != tga_pkg::TYPE_RLE)
                    begin
                        result.kind = tga_pkg::KIND_BAD_TYPE;
                        phase_next  = tga_pkg::PH_REJECT;
                    end
                    else
                    begin
                        four_bpp_next = (cur_held == tga_pkg::DEPTH_32);
                        total_next    = product;
                        done_next     = '0;
                        result.kind   = tga_pkg::KIND_HEADER_OK;
                        if (cur_width == 16'd0 || cur_height == 16'd0)
                        begin
                            result.end_of_image = 1'b1;
                            phase_next          = tga_pkg::PH_DONE;
                        end
                        else if (cur_img_kind == tga_pkg::TYPE_RLE)
                        begin
                            phase_next = tga_pkg::PH_PACKET;
                        end
                        else
                        begin
                            phase_next = tga_pkg::PH_PIXEL;
                        end
                    end
                    held_next = '0;
                    bpos_next = '0;
                end
            end

            tga_pkg::PH_PACKET:
            begin
                if (b < tga_pkg::RUN_FLAG)
                begin
                    is_run_next = 1'b0;
                    remain_next = b + 8'd1;
                end
                else
                begin
                    is_run_next = 1'b1;
                    remain_next = b - tga_pkg::RUN_BIAS;
                end
                bpos_next  = '0;
                held_next  = '0;
                phase_next = tga_pkg::PH_PIXEL;
            end

            tga_pkg::PH_PIXEL:
            begin
                if (cur_bpos < last_pos)
                begin
                    unique case (cur_bpos)
                        2'd0:    held_next = cur_held | {16'd0, b};
                        2'd1:    held_next = cur_held | {8'd0, b, 8'd0};
                        default: held_next = cur_held | {b, 16'd0};
                    endcase
                    bpos_next = cur_bpos + 2'd1;
                end
                else
                begin
                    if (cur_img_kind == tga_pkg::TYPE_RLE && cur_is_run)
                    begin
                        rep         = ({24'd0, cur_remain} > left) ? left
                                                                   : {24'd0, cur_remain};
                        remain_next = '0;
                    end
                    else
                    begin
                        rep = 32'd1;
                        if (cur_img_kind == tga_pkg::TYPE_RLE && cur_remain != 8'd0)
                        begin
                            remain_next = cur_remain - 8'd1;
                        end
                    end
                    has_result          = 1'b1;
                    result.kind         = tga_pkg::KIND_PIXEL;
                    result.red          = cur_four_bpp ? cur_held[23:16] : b;
                    result.green        = cur_held[15:8];
                    result.blue         = cur_held[7:0];
                    result.alpha        = cur_four_bpp ? b : tga_pkg::ALPHA_OPAQUE;
                    result.repeat_count = rep[7:0];
                    result.pixel_index  = cur_done;
                    done_next           = cur_done + rep;
                    bpos_next           = '0;
                    held_next           = '0;
                    // The repeat never passes the pixels left, so equality marks the end.
                    if (rep == left)
                    begin
                        result.end_of_image = 1'b1;
                        phase_next          = tga_pkg::PH_DONE;
                    end
                    else if (cur_img_kind == tga_pkg::TYPE_RLE && remain_next == 8'd0)
                    begin
                        phase_next = tga_pkg::PH_PACKET;
                    end
                    else
                    begin
                        phase_next = tga_pkg::PH_PIXEL;
                    end
                end
            end

            tga_pkg::PH_DONE,
            tga_pkg::PH_REJECT:
            begin
            end

            default:
            begin
                phase_next = tga_pkg::PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tga_pkg::PH_HEADER;
            hpos_reg     <= '0;
            img_kind_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            four_bpp_reg <= 1'b0;
            remain_reg   <= '0;
            is_run_reg   <= 1'b0;
            bpos_reg     <= '0;
            held_reg     <= '0;
            done_reg     <= '0;
            total_reg    <= '0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            hpos_reg     <= hpos_next;
            img_kind_reg <= img_kind_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            four_bpp_reg <= four_bpp_next;
            remain_reg   <= remain_next;
            is_run_reg   <= is_run_next;
            bpos_reg     <= bpos_next;
            held_reg     <= held_next;
            done_reg     <= done_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire && has_result)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_fire && has_result)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    `TGA_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)

    `TGA_ASSERT_SAME(a_pixel_rep_nonzero, clk, rst_n,
        out_valid_reg && out_reg.kind == tga_pkg::KIND_PIXEL, out_reg.repeat_count != 8'd0)

    `TGA_ASSERT_SAME(a_done_below_total, clk, rst_n,
        phase_reg == tga_pkg::PH_PIXEL || phase_reg == tga_pkg::PH_PACKET, done_reg < total_reg)

    `TGA_ASSERT_SAME(a_end_kind, clk, rst_n, out_valid_reg && out_reg.end_of_image,
        out_reg.kind == tga_pkg::KIND_PIXEL || out_reg.kind == tga_pkg::KIND_HEADER_OK)

    `TGA_ASSERT_NEXT(a_stall_holds_beat, clk, rst_n, out_valid_reg && !out_ready,
        out_valid_reg && $stable(out_reg))

endmodule

`default_nettype wire
